// ===== rtl/sme_pkg.sv =====
package sme_pkg;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_EQ    = 4'd5,
    OP_HALT  = 4'd6,
    OP_JNZ   = 4'd7,
    OP_JMP   = 4'd8
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_HALTED = 3'd4,
    ST_RANGE  = 3'd5
  } status_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [63:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_ip;
    logic [63:0] top_value;
    logic [4:0]  stack_depth;
    logic        halted;
    logic [2:0]  status;
  } out_item_t;

  // Decoded instruction handed from front to back
  typedef struct packed {
    logic        is_push;
    logic        is_bin;
    logic        is_halt;
    logic        is_jnz;
    logic        is_jmp;
    logic [3:0]  opcode;
    logic [63:0] immediate;
  } dec_item_t;

endpackage

// ===== rtl/sme_front.sv =====
module sme_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sme_pkg::in_item_t   in_data_i,
  output logic                dec_valid_o,
  input  logic                dec_ready_i,
  output sme_pkg::dec_item_t  dec_data_o
);
  import sme_pkg::*;

  // Two-entry queue of decoded instructions
  dec_item_t  fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  dec_item_t  dec;

  // Classify the opcode
  always_comb begin
    dec = '0;
    dec.opcode    = in_data_i.opcode;
    dec.immediate = in_data_i.immediate;
    unique case (in_data_i.opcode) inside
      OP_PUSH:                      dec.is_push = 1'b1;
      OP_ADD, OP_SUB, OP_MUL,
      OP_DIV, OP_EQ:                dec.is_bin  = 1'b1;
      OP_HALT:                      dec.is_halt = 1'b1;
      OP_JNZ:                       dec.is_jnz  = 1'b1;
      OP_JMP:                       dec.is_jmp  = 1'b1;
      default:                      ;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign dec_valid_o = (cnt_q != 2'd0);
  assign dec_data_o  = fifo_q[rd_ptr_q];

  logic push, pop;
  assign push = in_valid_i && in_ready_o;
  assign pop  = dec_valid_o && dec_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= dec;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/sme_muldiv.sv =====
module sme_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_div_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);
  // Shift-add multiply / restoring divide, one bit per cycle
  logic        busy_q, div_q;
  logic [6:0]  cnt_q;
  logic [63:0] acc_q, opa_q, opb_q;
  logic [64:0] rem_sh, rem_sub;

  assign rem_sh  = {acc_q, opa_q[63]};
  assign rem_sub = rem_sh - {1'b0, opb_q};

  assign done_o   = busy_q && (cnt_q == 7'd64);
  assign result_o = div_q ? opa_q : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= is_div_i;
      acc_q <= '0;
      opa_q <= a_i;
      opb_q <= b_i;
    end else if (busy_q && !done_o) begin
      if (div_q) begin
        // Shift dividend bit into remainder, quotient bits fill opa
        if (!rem_sub[64]) acc_q <= rem_sub[63:0];
        else              acc_q <= rem_sh[63:0];
        opa_q <= {opa_q[62:0], ~rem_sub[64]};
      end else begin
        if (opb_q[0]) acc_q <= acc_q + opa_q;
        opa_q <= {opa_q[62:0], 1'b0};
        opb_q <= {1'b0, opb_q[63:1]};
      end
    end
  end
endmodule

// ===== rtl/sme_back.sv =====
module sme_back #(
  parameter int STACK_DEPTH = 16,
  parameter int IP_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                dec_valid_i,
  output logic                dec_ready_o,
  input  sme_pkg::dec_item_t  dec_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sme_pkg::out_item_t  out_data_o
);
  import sme_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD1   = 3'd1;
  localparam logic [2:0] S_RD2   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MD    = 3'd4;
  localparam logic [2:0] S_TOP   = 3'd5;
  localparam logic [2:0] S_TOPW  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [63:0]        mem_q [STACK_DEPTH];
  logic [2:0]         state_q;
  logic [DW-1:0]      depth_q;
  logic [IP_BITS-1:0] ip_q;
  logic               halt_q;
  dec_item_t          ins_q;
  logic [63:0]        a_q, b_q, rd_q, top_q;
  logic [2:0]         st_q;
  out_item_t          out_q;
  logic               out_valid_q;

  // Single read port, single write port memory
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [63:0]   mem_wd;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  logic        md_start, md_done;
  logic [63:0] md_res;
  sme_muldiv u_md (
    .clk_i, .rst_ni,
    .start_i (md_start),
    .is_div_i(ins_q.opcode == OP_DIV),
    .a_i     (a_q),
    .b_i     (b_q),
    .done_o  (md_done),
    .result_o(md_res)
  );

  logic [DW-1:0] dm1, dm2;
  logic          ip_fits;
  logic [IP_BITS-1:0] ip_inc;
  assign dm1 = depth_q - DW'(1);
  assign dm2 = depth_q - DW'(2);
  assign ip_inc = ip_q + IP_BITS'(1);
  assign ip_fits = (ins_q.immediate >> IP_BITS) == 64'd0;

  assign dec_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = dm2[AW-1:0];
    mem_wd   = ins_q.immediate;
    mem_ra   = dm1[AW-1:0];
    md_start = 1'b0;
    if (state_q == S_IDLE) begin
      mem_ra = depth_q[AW-1:0] - AW'(1);
    end else if (state_q == S_RD1) begin
      mem_ra = dm2[AW-1:0];
    end else if (state_q == S_EXEC) begin
      md_start = ins_q.is_bin && (ins_q.opcode == OP_MUL ||
                 (ins_q.opcode == OP_DIV && b_q != 64'd0)) && st_q == ST_OK;
    end else if (state_q == S_TOP) begin
      mem_ra = dm1[AW-1:0];
    end
    if (state_q == S_EXEC && st_q == ST_OK && !md_start) begin
      if (ins_q.is_push) begin
        mem_we = 1'b1;
        mem_wa = depth_q[AW-1:0];
      end else if (ins_q.is_bin) begin
        mem_we = 1'b1;
        unique case (ins_q.opcode)
          OP_ADD:  mem_wd = a_q + b_q;
          OP_SUB:  mem_wd = a_q - b_q;
          default: mem_wd = {63'd0, a_q == b_q};
        endcase
      end
    end else if (state_q == S_MD && md_done) begin
      mem_we = 1'b1;
      mem_wd = md_res;
    end
  end

  // Sequence one instruction: read operands, check, execute, read new top, register result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      ip_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (dec_valid_i && dec_ready_o) begin
          ins_q   <= dec_data_i;
          state_q <= S_RD1;
        end
        S_RD1: begin
          b_q     <= rd_q;
          state_q <= S_RD2;
        end
        S_RD2: begin
          a_q     <= rd_q;
          state_q <= S_EXEC;
          if (halt_q) st_q <= ST_HALTED;
          else if (ins_q.is_push && depth_q >= DW'(STACK_DEPTH)) st_q <= ST_OVER;
          else if (ins_q.is_bin && depth_q < DW'(2)) st_q <= ST_UNDER;
          else if (ins_q.is_jnz && depth_q < DW'(1)) st_q <= ST_UNDER;
          else if (ins_q.is_bin && ins_q.opcode == OP_DIV && b_q == 64'd0)
            st_q <= ST_DIVZ;
          else if ((ins_q.is_jmp || (ins_q.is_jnz && b_q != 64'd0)) && !ip_fits)
            st_q <= ST_RANGE;
          else st_q <= ST_OK;
        end
        S_EXEC: begin
          state_q <= S_TOP;
          if (st_q == ST_OK) begin
            if (md_start) state_q <= S_MD;
            else if (ins_q.is_push) begin
              depth_q <= depth_q + DW'(1);
              ip_q    <= ip_inc;
            end else if (ins_q.is_bin) begin
              depth_q <= dm1;
              ip_q    <= ip_inc;
            end else if (ins_q.is_halt) begin
              halt_q <= 1'b1;
              ip_q   <= ip_inc;
            end else if (ins_q.is_jnz) begin
              depth_q <= dm1;
              ip_q    <= (b_q != 64'd0) ? ins_q.immediate[IP_BITS-1:0] : ip_inc;
            end else if (ins_q.is_jmp) begin
              ip_q <= ins_q.immediate[IP_BITS-1:0];
            end
          end
        end
        S_MD: if (md_done) begin
          depth_q <= dm1;
          ip_q    <= ip_inc;
          state_q <= S_TOP;
        end
        S_TOP:  state_q <= S_TOPW;
        S_TOPW: begin
          top_q   <= rd_q;
          state_q <= S_OUT;
        end
        default: begin
          out_q.next_ip     <= 16'(ip_q);
          out_q.top_value   <= (depth_q != '0) ? top_q : 64'd0;
          out_q.stack_depth <= 5'(depth_q);
          out_q.halted      <= halt_q;
          out_q.status      <= st_q;
          out_valid_q       <= 1'b1;
          state_q           <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/stack_machine_execute.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | sme_pkg::in_item_t
// out     | output    | out_valid_o/out_ready_i | sme_pkg::out_item_t
//
// A result is registered after operand reads, checks, execute and a top read;
// mul and a nonzero div also pass through the bit-serial multiply/divide unit.
// The back end can take its next instruction in the cycle after the result is taken.
// The front queue holds two decoded transactions while the back end works.
// Reset clears pointer, depth and halt flag; stack contents are not cleared.
// A stalled output holds the back end until the result is taken.
module stack_machine_execute #(
  parameter int STACK_DEPTH = 16,
  parameter int IP_BITS     = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sme_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sme_pkg::out_item_t out_data_o
);
  import sme_pkg::*;

  logic      dec_valid, dec_ready;
  dec_item_t dec_data;

  sme_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .dec_valid_o(dec_valid), .dec_ready_i(dec_ready), .dec_data_o(dec_data)
  );

  sme_back #(.STACK_DEPTH(STACK_DEPTH), .IP_BITS(IP_BITS)) u_back (
    .clk_i, .rst_ni,
    .dec_valid_i(dec_valid), .dec_ready_o(dec_ready), .dec_data_i(dec_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
